FILE: src/clns_pkg.sv
// ----------------------------------------------------------------------------
// clns_pkg - shared types and tables of the character-LCD nibble sequencer
// Request codes, the job record passed from front to back, the nibble
// result record and the constant tables for init and row addressing.
// ----------------------------------------------------------------------------
package clns_pkg;

	localparam int OP_W = 2;

	localparam logic [OP_W-1:0] OP_INIT = 2'd0;
	localparam logic [OP_W-1:0] OP_CMD  = 2'd1;
	localparam logic [OP_W-1:0] OP_CHAR = 2'd2;
	localparam logic [OP_W-1:0] OP_GOTO = 2'd3;

	localparam logic [7:0] CMD_CLEAR = 8'h01;
	localparam logic [7:0] CMD_HOME  = 8'h02;
	localparam logic [7:0] CMD_DDRAM = 8'h80;

	localparam logic [12:0] WAIT_SHORT_US = 13'd55;
	localparam logic [12:0] WAIT_LONG_US  = 13'd2000;

	localparam int STEP_W    = 4;
	localparam int INIT_LAST = 13;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// one classified request: the whole init run, or one byte to send
	typedef struct packed {
		logic       is_init;
		logic       rs;
		logic [7:0] value;
	} clns_job_t;

	typedef struct packed {
		logic        rs;
		logic [3:0]  nibble;
		logic [14:0] wait_before_us;
		logic [12:0] wait_after_us;
		logic        last;
	} clns_res_t;

	function automatic logic [7:0] row_base(input logic [2:0] row);
		logic [7:0] b;
		case (row)
			3'd2:    b = 8'h40;
			3'd3:    b = 8'h14;
			3'd4:    b = 8'h54;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// power-up run: wake nibbles, then 0x28, 0x0C, 0x01, 0x06, 0x80 as byte pairs
	function automatic clns_res_t init_step(input logic [STEP_W-1:0] step);
		clns_res_t r;
		r.rs             = 1'b0;
		r.wait_before_us = 15'd0;
		r.last           = 1'b0;
		case (step)
			4'd0: begin
				r.nibble = 4'h3; r.wait_before_us = 15'd20000; r.wait_after_us = 13'd5000;
			end
			4'd1:  begin r.nibble = 4'h3; r.wait_after_us = 13'd100; end
			4'd2:  begin r.nibble = 4'h3; r.wait_after_us = 13'd100; end
			4'd3:  begin r.nibble = 4'h2; r.wait_after_us = 13'd100; end
			4'd4:  begin r.nibble = 4'h2; r.wait_after_us = 13'd0; end
			4'd5:  begin r.nibble = 4'h8; r.wait_after_us = WAIT_SHORT_US; end
			4'd6:  begin r.nibble = 4'h0; r.wait_after_us = 13'd0; end
			4'd7:  begin r.nibble = 4'hC; r.wait_after_us = WAIT_SHORT_US; end
			4'd8:  begin r.nibble = 4'h0; r.wait_after_us = 13'd0; end
			4'd9:  begin r.nibble = 4'h1; r.wait_after_us = WAIT_LONG_US; end
			4'd10: begin r.nibble = 4'h0; r.wait_after_us = 13'd0; end
			4'd11: begin r.nibble = 4'h6; r.wait_after_us = WAIT_SHORT_US; end
			4'd12: begin r.nibble = 4'h8; r.wait_after_us = 13'd0; end
			4'd13: begin r.nibble = 4'h0; r.wait_after_us = WAIT_SHORT_US; r.last = 1'b1; end
			default: begin r.nibble = 4'h0; r.wait_after_us = 13'd0; end
		endcase
		return r;
	endfunction

endpackage

FILE: src/clns_front.sv
// ----------------------------------------------------------------------------
// clns_front - request decode
// Accepts requests, turns each into a job (init run or one byte with its
// register-select level) and holds it in a register until the queue takes it.
// ----------------------------------------------------------------------------
module clns_front
	import clns_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [OP_W-1:0]  operation,
	input  logic [7:0]       byte_value,
	input  logic [5:0]       column,
	input  logic [2:0]       row,
	output logic             job_valid,
	input  logic             job_ready,
	output clns_job_t        job
);

	logic      valid_s1;
	clns_job_t job_s1;
	clns_job_t job_d;
	logic [7:0] addr;

	assign addr = 8'(row_base(row) + {2'b00, column} - 8'd1);

	always_comb begin
		job_d.is_init = 1'b0;
		job_d.rs      = 1'b0;
		job_d.value   = byte_value;
		unique case (operation)
			OP_INIT: job_d.is_init = 1'b1;
			OP_CMD:  job_d.rs = 1'b0;
			OP_CHAR: job_d.rs = 1'b1;
			OP_GOTO: job_d.value = CMD_DDRAM | addr;
			default: job_d.is_init = 1'b0;
		endcase
	end

	assign in_ready  = !valid_s1 || job_ready;
	assign job_valid = valid_s1;
	assign job       = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			job_s1 <= job_d;
		end
	end

endmodule

FILE: src/clns_queue.sv
// ----------------------------------------------------------------------------
// clns_queue - job queue
// Short FIFO between decode and nibble sequencing so each side stalls alone.
// ----------------------------------------------------------------------------
module clns_queue
	import clns_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  clns_job_t push_job,
	output logic      head_valid,
	input  logic      pop,
	output clns_job_t head_job
);

	clns_job_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QPTR_W:0]     count_q;
	logic                push;
	logic                pop_ok;

	assign push_ready = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_job   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop_ok     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop_ok) rd_q <= rd_q + 1'b1;
			if (push && !pop_ok) count_q <= count_q + 1'b1;
			else if (!push && pop_ok) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

endmodule

FILE: src/clns_back.sv
// ----------------------------------------------------------------------------
// clns_back - nibble sequencer
// Walks the job at the queue head one nibble per cycle, while the output register
// is free or being taken, into that register; pops the job on its final nibble.
// ----------------------------------------------------------------------------
module clns_back
	import clns_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  clns_job_t head_job,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output clns_res_t out_res
);

	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	clns_res_t         out_res_q;
	clns_res_t         res_d;
	logic              advance;
	logic              final_step;
	logic              long_wait;

	assign long_wait = !head_job.rs &&
		(head_job.value == CMD_CLEAR || head_job.value == CMD_HOME);

	always_comb begin
		if (head_job.is_init) begin
			res_d = init_step(step_q);
		end else begin
			res_d.rs             = head_job.rs;
			res_d.wait_before_us = 15'd0;
			if (!step_q[0]) begin
				res_d.nibble        = head_job.value[7:4];
				res_d.wait_after_us = 13'd0;
				res_d.last          = 1'b0;
			end else begin
				res_d.nibble        = head_job.value[3:0];
				res_d.wait_after_us = long_wait ? WAIT_LONG_US : WAIT_SHORT_US;
				res_d.last          = 1'b1;
			end
		end
	end

	assign final_step = head_job.is_init ? (step_q == STEP_W'(INIT_LAST)) : step_q[0];
	assign advance    = head_valid && (!out_valid_q || out_ready);
	assign pop        = advance && final_step;
	assign out_valid  = out_valid_q;
	assign out_res    = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				step_q <= final_step ? '0 : step_q + 1'b1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_res_q <= res_d;
		end
	end

endmodule

FILE: src/char_lcd_nibble_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer - character-LCD 4-bit bus nibble sequencer
// Expands init, command, character and cursor requests into register-select
// nibbles with the waits to apply before and after each enable strobe.
//
//   channel | dir | tdata (low bit up)                         | tuser      | tlast
//   s_      | in  | byte_value[7:0] column[13:8] row[16:14]     | operation  | -
//   m_      | out | nibble[3:0] wait_before[18:4] wait_after[31:19] | reg_select | last_of_run
//
// A request is accepted each cycle while the job queue has room; results leave
// one nibble per cycle from the output register while m_tready holds, so a byte
// request gives two nibbles and init gives fourteen, set by the single nibble sequencer.
// A request passes the decode register and the job queue before its first result is registered.
// Reset clears the decode stage, queue pointers, step counter and output valid.
// Either side may stall freely; the four-entry queue decouples them.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer
	import clns_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // byte_value[7:0], column[13:8], row[16:14], zero pad
	input  logic [1:0]  s_tuser,   // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // nibble[3:0], wait_before_us[18:4], wait_after_us[31:19]
	output logic        m_tuser,   // reg_select
	output logic        m_tlast
);

	logic      job_valid;
	logic      job_ready;
	clns_job_t job;
	logic      head_valid;
	clns_job_t head_job;
	logic      pop;
	clns_res_t res;

	clns_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.operation  (s_tuser),
		.byte_value (s_tdata[7:0]),
		.column     (s_tdata[13:8]),
		.row        (s_tdata[16:14]),
		.job_valid  (job_valid),
		.job_ready  (job_ready),
		.job        (job)
	);

	clns_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (job_valid),
		.push_ready (job_ready),
		.push_job   (job),
		.head_valid (head_valid),
		.pop        (pop),
		.head_job   (head_job)
	);

	clns_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_res    (res)
	);

	assign m_tdata = {res.wait_after_us, res.wait_before_us, res.nibble};
	assign m_tuser = res.rs;
	assign m_tlast = res.last;

endmodule

FILE: bench/clns_strobe_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clns_strobe_checker - result checker for the character-LCD nibble sequencer
// Watches both stream channels. Every accepted request is expanded here into
// the nibble strobes the panel should see. Each accepted result is compared
// field by field against the oldest strobe still waiting.
// ----------------------------------------------------------------------------
module clns_strobe_checker
	import clns_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // byte_value[7:0], column[13:8], row[16:14], zero pad
	input  logic [1:0]  s_tuser,   // operation[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // nibble[3:0], wait_before_us[18:4], wait_after_us[31:19]
	input  logic        m_tuser,   // reg_select
	input  logic        m_tlast,
	output int          mismatches,
	output int          pending,
	output int          strobes_checked
);

	localparam logic [3:0]  WAKE_NIBBLE     = 4'h3;
	localparam logic [3:0]  BUS_4BIT_NIBBLE = 4'h2;
	localparam logic [14:0] POWER_UP_US     = 15'd20000;
	localparam logic [12:0] FIRST_WAKE_US   = 13'd5000;
	localparam logic [12:0] WAKE_US         = 13'd100;
	localparam logic [7:0]  FUNC_4BIT_2LINE = 8'h28;
	localparam logic [7:0]  DISPLAY_ON      = 8'h0C;
	localparam logic [7:0]  ENTRY_INCREMENT = 8'h06;
	localparam int          MAX_PRINTED     = 40;

	typedef struct packed {
		logic        rs;
		logic [3:0]  nib;
		logic [14:0] wait_pre;
		logic [12:0] wait_post;
		logic        run_end;
	} lcd_strobe_t;

	lcd_strobe_t expected_strobes[$];
	lcd_strobe_t want;
	int          fail_total   = 0;
	int          strobe_total = 0;

	task automatic report_mismatch(input string msg);
		if (fail_total < MAX_PRINTED)
			$display("[%0t] mismatch: %s", $realtime, msg);
		fail_total++;
	endtask

	task automatic check_field(input string name, input int got, input int exp_val);
		if (got != exp_val)
			report_mismatch($sformatf("strobe %0d %s got %0d want %0d",
				strobe_total, name, got, exp_val));
	endtask

	task automatic push_strobe(input logic rs, input logic [3:0] nib,
			input logic [14:0] wait_pre, input logic [12:0] wait_post, input logic run_end);
		lcd_strobe_t s;
		s.rs        = rs;
		s.nib       = nib;
		s.wait_pre  = wait_pre;
		s.wait_post = wait_post;
		s.run_end   = run_end;
		expected_strobes.push_back(s);
	endtask

	// high nibble first; clear and home need the long execution wait
	task automatic push_byte(input logic rs, input logic [7:0] code, input logic run_end);
		logic [12:0] post;
		post = (!rs && (code == CMD_CLEAR || code == CMD_HOME)) ? WAIT_LONG_US : WAIT_SHORT_US;
		push_strobe(rs, code[7:4], '0, '0, 1'b0);
		push_strobe(rs, code[3:0], '0, post, run_end);
	endtask

	task automatic predict_strobes(input logic [1:0] op, input logic [7:0] code,
			input logic [5:0] col, input logic [2:0] row);
		logic [7:0] base;
		logic [7:0] addr;
		case (op)
			OP_INIT: begin
				push_strobe(1'b0, WAKE_NIBBLE, POWER_UP_US, FIRST_WAKE_US, 1'b0);
				push_strobe(1'b0, WAKE_NIBBLE, '0, WAKE_US, 1'b0);
				push_strobe(1'b0, WAKE_NIBBLE, '0, WAKE_US, 1'b0);
				push_strobe(1'b0, BUS_4BIT_NIBBLE, '0, WAKE_US, 1'b0);
				push_byte(1'b0, FUNC_4BIT_2LINE, 1'b0);
				push_byte(1'b0, DISPLAY_ON, 1'b0);
				push_byte(1'b0, CMD_CLEAR, 1'b0);
				push_byte(1'b0, ENTRY_INCREMENT, 1'b0);
				push_byte(1'b0, CMD_DDRAM, 1'b1);
			end
			OP_CMD:  push_byte(1'b0, code, 1'b1);
			OP_CHAR: push_byte(1'b1, code, 1'b1);
			default: begin
				// rows outside 1..4 fall back to the first row; address wraps to 8 bits
				case (row)
					3'd2:    base = 8'h40;
					3'd3:    base = 8'h14;
					3'd4:    base = 8'h54;
					default: base = 8'h00;
				endcase
				addr = base + {2'b00, col} - 8'd1;
				push_byte(1'b0, CMD_DDRAM | addr, 1'b1);
			end
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_strobes(s_tuser, s_tdata[7:0], s_tdata[13:8], s_tdata[16:14]);
			if (m_tvalid && m_tready) begin
				if (expected_strobes.size() == 0) begin
					report_mismatch($sformatf("strobe %0d arrived with nothing expected",
						strobe_total));
				end else begin
					want = expected_strobes.pop_front();
					check_field("reg_select", m_tuser, want.rs);
					check_field("nibble", m_tdata[3:0], want.nib);
					check_field("wait_before_us", m_tdata[18:4], want.wait_pre);
					check_field("wait_after_us", m_tdata[31:19], want.wait_post);
					check_field("last_of_run", m_tlast, want.run_end);
				end
				strobe_total++;
			end
		end
		pending         <= expected_strobes.size();
		strobes_checked <= strobe_total;
		mismatches      <= fail_total;
	end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the character-LCD nibble sequencer
// Sends directed init, command, character and cursor requests, then a long
// random mix with random gaps on both channels. The checker beside the block
// predicts every nibble strobe; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import clns_pkg::*;

	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 7;
	localparam int RANDOM_REQUESTS = 410;
	localparam int MAX_GAP         = 13;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int SETTLE_CYCLES   = 20;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;    // byte_value[7:0], column[13:8], row[16:14], zero pad
	logic [1:0]  s_tuser  = '0;    // operation[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;          // nibble[3:0], wait_before_us[18:4], wait_after_us[31:19]
	logic        m_tuser;          // reg_select
	logic        m_tlast;

	int mismatches;
	int pending;
	int strobes_checked;
	int quiet_cycles = 0;
	int req_count[4] = '{0, 0, 0, 0};
	bit tx_idle      = 1'b1;
	bit rx_idle      = 1'b1;

	always #(CLK_PERIOD / 2) clk = ~clk;

	char_lcd_nibble_sequencer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	clns_strobe_checker u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.m_tlast         (m_tlast),
		.mismatches      (mismatches),
		.pending         (pending),
		.strobes_checked (strobes_checked)
	);

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side: draw a stall per strobe, then hold ready until it is taken
	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic send_request(input logic [1:0] op, input logic [7:0] code,
			input logic [5:0] col, input logic [2:0] row);
		int gap;
		gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, row, col, code};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		req_count[op]++;
	endtask

	// drop valid and hold until every predicted strobe has arrived
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int         pick;
		logic [1:0] op;
		logic [7:0] code;
		logic [5:0] col;
		logic [2:0] row;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_INIT, 8'hFF, 6'h3F, 3'd7);
		send_request(OP_CMD, 8'h00, 6'h00, 3'd0);
		send_request(OP_CMD, 8'hFF, 6'h3F, 3'd7);
		send_request(OP_CMD, CMD_CLEAR, 6'h15, 3'd2);
		send_request(OP_CMD, CMD_HOME, 6'h2A, 3'd5);
		send_request(OP_CMD, 8'h03, 6'h01, 3'd1);
		send_request(OP_CHAR, 8'h00, 6'h3F, 3'd7);
		send_request(OP_CHAR, 8'hFF, 6'h00, 3'd0);
		send_request(OP_CHAR, CMD_CLEAR, 6'h01, 3'd1);
		send_request(OP_CHAR, CMD_HOME, 6'h28, 3'd4);
		send_request(OP_GOTO, 8'hFF, 6'd1, 3'd1);
		send_request(OP_GOTO, 8'h00, 6'd40, 3'd2);
		send_request(OP_GOTO, 8'hA5, 6'd1, 3'd3);
		send_request(OP_GOTO, 8'h5A, 6'd40, 3'd4);
		send_request(OP_GOTO, 8'h00, 6'd5, 3'd0);
		send_request(OP_GOTO, 8'hFF, 6'd7, 3'd5);
		send_request(OP_GOTO, 8'h00, 6'd63, 3'd7);
		send_request(OP_GOTO, 8'hFF, 6'd0, 3'd1);
		send_request(OP_GOTO, 8'h00, 6'd63, 3'd4);
		send_request(OP_GOTO, 8'h00, 6'd0, 3'd6);
		send_request(OP_INIT, 8'h00, 6'h00, 3'd0);
		drain_results();

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			// rotate gap patterns so each side runs both stalled and flat out
			if (i % 40 == 0) begin
				tx_idle = ((i / 40) % 4) inside {0, 2};
				rx_idle = ((i / 40) % 4) inside {0, 1};
			end
			pick = $urandom_range(0, 99);
			if (pick < 3)       op = OP_INIT;
			else if (pick < 33) op = OP_CMD;
			else if (pick < 63) op = OP_CHAR;
			else                op = OP_GOTO;
			code = 8'($urandom_range(0, 255));
			if (op == OP_CMD && $urandom_range(0, 3) == 0)
				code = $urandom_range(0, 1) ? CMD_CLEAR : CMD_HOME;
			row = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4))
				: 3'($urandom_range(0, 7));
			col = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(1, 40))
				: 6'($urandom_range(0, 63));
			send_request(op, code, col, row);
			if (i % 100 == 99)
				drain_results();
		end
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Requests sent: %0d init, %0d command, %0d character, %0d cursor move",
			req_count[OP_INIT], req_count[OP_CMD], req_count[OP_CHAR], req_count[OP_GOTO]);
		$display("Nibble strobes compared: %0d, mismatches: %0d", strobes_checked, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
